### sv/cxalu_pkg.sv
// Package for the packed Q15 complex ALU: beat types, stage types and widths.
package cxalu_pkg;

	// Width of one packed half (real or imaginary).
	localparam int HALF_W = 16;
	// Width of a packed operand or result word.
	localparam int WORD_W = 2 * HALF_W;
	// Exact width of a full-precision component (sum of two Q15 products).
	localparam int COMP_W = 2 * HALF_W + 1;
	// Component width with headroom for the rounding bias.
	localparam int WIDE_W = COMP_W + 1;
	// Width of the shift amount.
	localparam int SHIFT_W = 5;

	// Request codes.
	typedef enum logic [1:0] {
		REQ_MULCONJ    = 2'd0,
		REQ_BFLY       = 2'd1,
		REQ_BFLY_CROSS = 2'd2,
		REQ_RESERVED   = 2'd3
	} req_type_t;

	// One command beat.
	typedef struct packed {
		req_type_t           req_type;
		logic [WORD_W-1:0]   operand_a;
		logic [WORD_W-1:0]   operand_b;
		logic [SHIFT_W-1:0]  shift;
		logic                round_nearest;
		logic                saturate;
		logic                imag_high;
	} cmd_t;

	// One result beat.
	typedef struct packed {
		logic [WORD_W-1:0] result_first;
		logic [WORD_W-1:0] result_second;
	} res_t;

	// Narrowing controls shared by all four components.
	typedef struct packed {
		logic [SHIFT_W-1:0] shift;
		logic               round_nearest;
		logic               saturate;
	} narrow_ctl_t;

	// Full-precision components, already placed in their output positions.
	typedef struct packed {
		logic signed [COMP_W-1:0] first_hi;
		logic signed [COMP_W-1:0] first_lo;
		logic signed [COMP_W-1:0] second_hi;
		logic signed [COMP_W-1:0] second_lo;
		narrow_ctl_t              ctl;
	} comp_t;

endpackage

### sv/packed_q15_complex_alu.sv
// Top level of the packed Q15 complex ALU: three-stage pipeline with handshake.
//
// Usage
//   Command channel (cmd, cmd_valid, cmd_stall): a beat carries the request
//   type, two packed complex operands (imaginary in 31:16, real in 15:0) and
//   the shift, rounding, saturation and layout controls. A beat is taken at a
//   rising edge with cmd_valid high and cmd_stall low.
//   Result channel (res, res_valid, res_stall): one beat per command, in
//   order, taken at an edge with res_valid high and res_stall low.
//   From command beat to result valid a beat passes an input register, a
//   register after the full-precision products and butterfly sums, and a
//   result register after narrowing and packing. Throughput is one beat
//   per cycle while res_stall is low; the multiply stage sets the clock.
//   While the receiver stalls, the pipeline keeps filling its empty stages,
//   so up to three beats are held; cmd_stall rises only when all three
//   stages are full and the result beat is stalled.
//   Reset clears all stage valid flags; no result beat follows reset until a
//   command beat has been taken.
module packed_q15_complex_alu (
	input  logic             clk,
	input  logic             arst_n,
	input  cxalu_pkg::cmd_t  cmd,
	input  logic             cmd_valid,
	output logic             cmd_stall,
	output cxalu_pkg::res_t  res,
	output logic             res_valid,
	input  logic             res_stall
);

	cxalu_pkg::cmd_t  cmd_s1;
	cxalu_pkg::comp_t comp_c;
	cxalu_pkg::comp_t comp_s2;
	cxalu_pkg::res_t  res_c;
	cxalu_pkg::res_t  res_s3;
	logic             valid_s1, valid_s2, valid_s3;
	logic             en_s1, en_s2, en_s3;

	// A stage may load when it is empty or its content moves on.
	assign en_s3     = !valid_s3 || !res_stall;
	assign en_s2     = !valid_s2 || en_s3;
	assign en_s1     = !valid_s1 || en_s2;
	assign cmd_stall = !en_s1;

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= cmd_valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (en_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// Input register.
	always_ff @(posedge clk) begin
		if (en_s1 && cmd_valid) begin
			cmd_s1 <= cmd;
		end
	end

	cxalu_arith u_arith (
		.cmd  (cmd_s1),
		.comp (comp_c)
	);

	// Full-precision component register.
	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1) begin
			comp_s2 <= comp_c;
		end
	end

	// Narrow the four components and pack them.
	cxalu_narrow u_narrow_fh (
		.comp (comp_s2.first_hi),
		.ctl  (comp_s2.ctl),
		.half (res_c.result_first[cxalu_pkg::WORD_W-1:cxalu_pkg::HALF_W])
	);

	cxalu_narrow u_narrow_fl (
		.comp (comp_s2.first_lo),
		.ctl  (comp_s2.ctl),
		.half (res_c.result_first[cxalu_pkg::HALF_W-1:0])
	);

	cxalu_narrow u_narrow_sh (
		.comp (comp_s2.second_hi),
		.ctl  (comp_s2.ctl),
		.half (res_c.result_second[cxalu_pkg::WORD_W-1:cxalu_pkg::HALF_W])
	);

	cxalu_narrow u_narrow_sl (
		.comp (comp_s2.second_lo),
		.ctl  (comp_s2.ctl),
		.half (res_c.result_second[cxalu_pkg::HALF_W-1:0])
	);

	// Result register.
	always_ff @(posedge clk) begin
		if (en_s3 && valid_s2) begin
			res_s3 <= res_c;
		end
	end

	assign res       = res_s3;
	assign res_valid = valid_s3;

	// A full middle stage that cannot move on still holds its beat.
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !en_s3) |=> valid_s2)
		else $error("middle stage lost a beat while stalled");

	// A beat leaving the middle stage lands in the result register.
	a_s2_to_s3: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && en_s3) |=> valid_s3)
		else $error("beat from middle stage did not reach result register");

	// Back-pressure reaches the command side only with every stage full.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> (valid_s1 && valid_s2 && valid_s3 && res_stall))
		else $error("command stalled with an empty stage");

endmodule

### sv/cxalu_arith.sv
// Full-precision arithmetic: multiply by conjugate and both butterfly variants.
module cxalu_arith (
	input  cxalu_pkg::cmd_t  cmd,
	output cxalu_pkg::comp_t comp
);

	logic signed [cxalu_pkg::HALF_W-1:0]   ar, ai, br, bi;
	logic signed [2*cxalu_pkg::HALF_W-1:0] p_rr, p_ii, p_ir, p_ri;
	logic signed [cxalu_pkg::COMP_W-1:0]   re, im;
	logic signed [cxalu_pkg::HALF_W:0]     sr, dr, si, di;
	logic signed [cxalu_pkg::COMP_W-1:0]   sr_x, dr_x, si_x, di_x;

	// Unpack the halves of both operands.
	assign ar = cmd.operand_a[cxalu_pkg::HALF_W-1:0];
	assign ai = cmd.operand_a[cxalu_pkg::WORD_W-1:cxalu_pkg::HALF_W];
	assign br = cmd.operand_b[cxalu_pkg::HALF_W-1:0];
	assign bi = cmd.operand_b[cxalu_pkg::WORD_W-1:cxalu_pkg::HALF_W];

	// Four Q15 products and the exact conjugate-product components.
	assign p_rr = (2*cxalu_pkg::HALF_W)'(ar) * (2*cxalu_pkg::HALF_W)'(br);
	assign p_ii = (2*cxalu_pkg::HALF_W)'(ai) * (2*cxalu_pkg::HALF_W)'(bi);
	assign p_ir = (2*cxalu_pkg::HALF_W)'(ai) * (2*cxalu_pkg::HALF_W)'(br);
	assign p_ri = (2*cxalu_pkg::HALF_W)'(ar) * (2*cxalu_pkg::HALF_W)'(bi);
	assign re   = cxalu_pkg::COMP_W'(p_rr) + cxalu_pkg::COMP_W'(p_ii);
	assign im   = cxalu_pkg::COMP_W'(p_ir) - cxalu_pkg::COMP_W'(p_ri);

	// Butterfly sums and differences, one bit wider than a half.
	assign sr   = (cxalu_pkg::HALF_W+1)'(ar) + (cxalu_pkg::HALF_W+1)'(br);
	assign dr   = (cxalu_pkg::HALF_W+1)'(ar) - (cxalu_pkg::HALF_W+1)'(br);
	assign si   = (cxalu_pkg::HALF_W+1)'(ai) + (cxalu_pkg::HALF_W+1)'(bi);
	assign di   = (cxalu_pkg::HALF_W+1)'(ai) - (cxalu_pkg::HALF_W+1)'(bi);
	assign sr_x = cxalu_pkg::COMP_W'(sr);
	assign dr_x = cxalu_pkg::COMP_W'(dr);
	assign si_x = cxalu_pkg::COMP_W'(si);
	assign di_x = cxalu_pkg::COMP_W'(di);

	// Place each component where it lands in the packed result.
	always_comb begin
		comp.ctl.shift         = cmd.shift;
		comp.ctl.round_nearest = cmd.round_nearest;
		comp.ctl.saturate      = cmd.saturate;
		comp.first_hi          = '0;
		comp.first_lo          = '0;
		comp.second_hi         = '0;
		comp.second_lo         = '0;
		unique case (cmd.req_type)
			cxalu_pkg::REQ_MULCONJ: begin
				comp.first_hi = cmd.imag_high ? im : re;
				comp.first_lo = cmd.imag_high ? re : im;
			end
			cxalu_pkg::REQ_BFLY: begin
				comp.first_hi  = si_x;
				comp.first_lo  = sr_x;
				comp.second_hi = di_x;
				comp.second_lo = dr_x;
			end
			cxalu_pkg::REQ_BFLY_CROSS: begin
				comp.first_hi  = di_x;
				comp.first_lo  = sr_x;
				comp.second_hi = si_x;
				comp.second_lo = dr_x;
			end
			default: begin
				// Reserved request: every component stays zero.
				comp.first_hi = '0;
			end
		endcase
	end

endmodule

### sv/cxalu_narrow.sv
// Narrowing of one component: shift, floor or round, then wrap or saturate.
module cxalu_narrow (
	input  logic signed [cxalu_pkg::COMP_W-1:0] comp,
	input  cxalu_pkg::narrow_ctl_t              ctl,
	output logic [cxalu_pkg::HALF_W-1:0]        half
);

	localparam logic signed [cxalu_pkg::WIDE_W-1:0] MAX_V =
		cxalu_pkg::WIDE_W'((1 <<< (cxalu_pkg::HALF_W - 1)) - 1);
	localparam logic signed [cxalu_pkg::WIDE_W-1:0] MIN_V =
		cxalu_pkg::WIDE_W'(-(1 <<< (cxalu_pkg::HALF_W - 1)));

	logic signed [cxalu_pkg::WIDE_W-1:0] x_ext, bias, biased, shifted;

	// Rounding bias is half an output step, and only when bits are dropped.
	always_comb begin
		x_ext = cxalu_pkg::WIDE_W'(comp);
		bias  = '0;
		if (ctl.round_nearest && ctl.shift != '0) begin
			bias = cxalu_pkg::WIDE_W'(1) << (ctl.shift - cxalu_pkg::SHIFT_W'(1));
		end
		biased  = x_ext + bias;
		shifted = biased >>> ctl.shift;
	end

	// Clamp to the signed 16-bit range or keep the low bits.
	always_comb begin
		half = shifted[cxalu_pkg::HALF_W-1:0];
		if (ctl.saturate) begin
			if (shifted > MAX_V) begin
				half = MAX_V[cxalu_pkg::HALF_W-1:0];
			end else if (shifted < MIN_V) begin
				half = MIN_V[cxalu_pkg::HALF_W-1:0];
			end
		end
	end

endmodule
